FILE: hdl/rbsq_pkg.sv
// Shared types, constants and the rotary code decoder for the scan qualifier.
`default_nettype none
package rbsq_pkg;

    localparam int NUM_ROTARY  = 4;
    localparam int BTN_W       = 8;
    localparam int CODE_W      = 4;
    localparam int POS_W       = 4;
    localparam int THR_W       = 16;

    localparam int S_DATA_W    = 24;
    localparam int M_FIELDS_W  = NUM_ROTARY * POS_W + NUM_ROTARY + 1 + 2 * BTN_W;
    localparam int M_DATA_W    = ((M_FIELDS_W + 7) / 8) * 8;

    localparam logic signed [POS_W-1:0] POS_NULL    = 4'sd4;
    localparam logic signed [POS_W-1:0] POS_INVALID = -4'sd1;
    localparam logic [THR_W-1:0]        THR_RESET   = 16'd10;

    typedef logic signed [POS_W-1:0] position_t;

    typedef struct packed {
        position_t position;
        logic      changed;
    } lane_result_t;

    // No bit set: null; one bit i: position 3-i; anything else is invalid.
    function automatic position_t decode_code(input logic [CODE_W-1:0] code);
        position_t pos;
        case (code)
            4'b0000: pos = POS_NULL;
            4'b0001: pos = 4'sd3;
            4'b0010: pos = 4'sd2;
            4'b0100: pos = 4'sd1;
            4'b1000: pos = 4'sd0;
            default: pos = POS_INVALID;
        endcase
        return pos;
    endfunction

endpackage
`default_nettype wire

FILE: hdl/rbsq_lane.sv
// One rotary lane: decode, change compare and null hold counter.
`default_nettype none
module rbsq_lane (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          advance,
    input  wire logic [rbsq_pkg::CODE_W-1:0]   code,
    input  wire logic [rbsq_pkg::THR_W-1:0]    threshold,
    output rbsq_pkg::lane_result_t             result
);
    import rbsq_pkg::*;

    position_t          prev_reg, prev_next;
    position_t          rep_reg, rep_next;
    logic [THR_W-1:0]   cnt_reg, cnt_next;
    position_t          dec;
    logic               ch;
    logic               flag;

    always_comb begin
        dec       = decode_code(code);
        ch        = (dec != prev_reg);
        prev_next = dec;
        rep_next  = rep_reg;
        cnt_next  = cnt_reg;
        flag      = 1'b0;
        if (dec == POS_NULL) begin
            if (ch) begin
                cnt_next = THR_W'(1);
            end else if (cnt_reg > threshold) begin
                rep_next = POS_NULL;
                flag     = 1'b1;
                cnt_next = '0;
            end else if (cnt_reg != '0) begin
                cnt_next = cnt_reg + THR_W'(1);
            end else begin
                rep_next = POS_NULL;
            end
        end else begin
            rep_next = dec;
            flag     = ch;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_reg <= '0;
            rep_reg  <= '0;
            cnt_reg  <= '0;
        end else if (advance) begin
            prev_reg <= prev_next;
            rep_reg  <= rep_next;
            cnt_reg  <= cnt_next;
        end
    end

    assign result.position = rep_next;
    assign result.changed  = flag;

    // a fresh null reading starts the hold count at one
    a_null_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && dec == POS_NULL && ch) |=> (cnt_reg == THR_W'(1)))
        else $error("hold counter not started on new null");

    // a flag on a null reading releases the counter
    a_null_release: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && flag && dec == POS_NULL) |=> (cnt_reg == '0 && rep_reg == POS_NULL))
        else $error("null release did not clear counter");

    // a held-back null never shows as changed
    a_hold_no_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        (dec == POS_NULL && rep_next != POS_NULL) |-> !flag)
        else $error("flag raised while null held");

endmodule
`default_nettype wire

FILE: hdl/rbsq_merge.sv
// Merge stage: gathers lane results and button changes into the output register.
`default_nettype none
module rbsq_merge (
    input  wire logic                                          aclk,
    input  wire logic                                          aresetn,
    input  wire logic                                          s_tvalid,
    output wire logic                                          s_tready,
    input  wire logic [rbsq_pkg::BTN_W-1:0]                    button_bits,
    input  wire rbsq_pkg::lane_result_t [rbsq_pkg::NUM_ROTARY-1:0] lanes,
    output wire logic                                          m_tvalid,
    input  wire logic                                          m_tready,
    output wire logic [rbsq_pkg::M_DATA_W-1:0]                 m_tdata
);
    import rbsq_pkg::*;

    logic                       valid_reg;
    logic [M_DATA_W-1:0]        data_reg, data_next;
    logic [BTN_W-1:0]           btn_prev_reg;
    logic [NUM_ROTARY-1:0]      chg;
    logic                       accept;

    assign s_tready = !valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        data_next = '0;
        for (int r = 0; r < NUM_ROTARY; r++) begin
            data_next[r*POS_W +: POS_W] = lanes[r].position;
            chg[r]                      = lanes[r].changed;
        end
        data_next[NUM_ROTARY*POS_W +: NUM_ROTARY]               = chg;
        data_next[NUM_ROTARY*POS_W + NUM_ROTARY]                = |chg;
        data_next[NUM_ROTARY*POS_W + NUM_ROTARY + 1 +: BTN_W]   = button_bits;
        data_next[NUM_ROTARY*POS_W + NUM_ROTARY + 1 + BTN_W +: BTN_W] =
            button_bits ^ btn_prev_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= 1'b0;
            btn_prev_reg <= '0;
        end else begin
            if (accept) begin
                valid_reg    <= 1'b1;
                btn_prev_reg <= button_bits;
            end else if (m_tready) begin
                valid_reg    <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            data_reg <= data_next;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;

    a_any_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg |-> (data_reg[NUM_ROTARY*POS_W + NUM_ROTARY] ==
                       |data_reg[NUM_ROTARY*POS_W +: NUM_ROTARY]))
        else $error("summary change flag disagrees with lane flags");

    a_btn_prev: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (btn_prev_reg == $past(button_bits)))
        else $error("previous button levels not captured");

    a_accept_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> valid_reg)
        else $error("accepted item produced no result");

endmodule
`default_nettype wire

FILE: hdl/rotary_and_button_scan_qualifier.sv
// Top level: four rotary lanes, button change merge, output register, threshold register.
//
//  channel | dir | handshake              | payload
//  s_      | in  | s_tvalid / s_tready    | s_tdata[23:0]
//  m_      | out | m_tvalid / m_tready    | m_tdata[39:0]
//  cfg_    | in  | cfg_we                 | cfg_wdata[15:0] null hold threshold
//
//  One item per cycle while s_tready is high; its result appears in the output register the next cycle.
//  Decode, compare and hold counters are one lane per rotary, all in one stage.
//  Reset (aresetn low, synchronous) clears lane state, button history, and
//  sets the threshold to 10.
//  s_tready is high while the output register is empty or being drained.
`default_nettype none
module rotary_and_button_scan_qualifier (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_tvalid,
    output wire logic                              s_tready,
    // button_bits[7:0], rotary_code_a[11:8], rotary_code_b[15:12],
    // rotary_code_c[19:16], rotary_code_d[23:20]
    input  wire logic [rbsq_pkg::S_DATA_W-1:0]     s_tdata,
    output wire logic                              m_tvalid,
    input  wire logic                              m_tready,
    // position_a[3:0], position_b[7:4], position_c[11:8], position_d[15:12],
    // rotary_change_bits[19:16], any_rotary_changed[20], button_levels[28:21],
    // button_change_bits[36:29], zero[39:37]
    output wire logic [rbsq_pkg::M_DATA_W-1:0]     m_tdata,
    input  wire logic                              cfg_we,
    input  wire logic [rbsq_pkg::THR_W-1:0]        cfg_wdata
);
    import rbsq_pkg::*;

    logic [THR_W-1:0]                   thr_reg;
    lane_result_t [NUM_ROTARY-1:0]      lane_res;
    logic                               ready;
    logic                               accept;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg <= THR_RESET;
        end else if (cfg_we) begin
            thr_reg <= cfg_wdata;
        end
    end

    assign accept = s_tvalid && ready;

    for (genvar r = 0; r < NUM_ROTARY; r++) begin : g_lane
        rbsq_lane u_lane (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .advance   (accept),
            .code      (s_tdata[BTN_W + r*CODE_W +: CODE_W]),
            .threshold (thr_reg),
            .result    (lane_res[r])
        );
    end

    rbsq_merge u_merge (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (ready),
        .button_bits (s_tdata[BTN_W-1:0]),
        .lanes       (lane_res),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    assign s_tready = ready;

endmodule
`default_nettype wire

FILE: sim/tb_top.sv
// Self-checking testbench for the rotary and button scan qualifier.
module tb_top;
    import rbsq_pkg::*;

    localparam int CYCLE_LIMIT   = 300000;
    localparam int PHASE_ITEMS   = 100;
    localparam int HOLD_OFF_LEN  = 400;

    // Scan item as it travels on s_tdata, buttons in the low byte.
    typedef struct packed {
        logic [NUM_ROTARY-1:0][CODE_W-1:0] codes;
        logic [BTN_W-1:0]                  buttons;
    } scan_t;

    // Report item as it travels on m_tdata.
    typedef struct packed {
        logic [2:0]                   pad;
        logic [BTN_W-1:0]             btn_chg;
        logic [BTN_W-1:0]             btn;
        logic                         any_chg;
        logic [NUM_ROTARY-1:0]        rot_chg;
        position_t [NUM_ROTARY-1:0]   pos;
    } report_t;

    typedef struct {
        logic [S_DATA_W-1:0] scan;     // code_d code_c code_b code_a buttons
        bit                  typed;
        position_t           pos [NUM_ROTARY];
        logic [3:0]          rot_chg;
        logic [7:0]          btn_chg;
    } scan_row_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_DATA_W-1:0]  s_tdata = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_DATA_W-1:0]  m_tdata;
    logic                 cfg_we = 1'b0;
    logic [THR_W-1:0]     cfg_wdata = '0;

    // Predictor state
    logic [THR_W-1:0]     hold_thr = THR_RESET;
    position_t            last_decoded [NUM_ROTARY] = '{default: '0};
    logic [THR_W-1:0]     hold_cnt [NUM_ROTARY] = '{default: '0};
    position_t            shown_pos [NUM_ROTARY] = '{default: '0};
    logic [BTN_W-1:0]     last_buttons = '0;

    report_t              pending_reports [$];
    int                   fail_count = 0;
    int                   reports_seen = 0;
    int                   cycle_count = 0;
    int                   rx_gap = 0;
    bit                   rx_block = 1'b0;
    bit                   quiet = 1'b0;

    // Directed items: reset state, code extremes, every null-hold case at threshold 1
    scan_row_t scan_table [21] = '{
        '{24'h0088_00, 1, '{0, 0, 0, 0}, 4'h0, 8'h00},
        '{24'h1248_FF, 1, '{0, 1, 2, 3}, 4'hE, 8'hFF},
        '{24'hF35A_55, 1, '{-1, -1, -1, -1}, 4'hF, 8'hAA},
        '{24'h0000_AA, 1, '{-1, -1, -1, -1}, 4'h0, 8'hFF},
        '{24'h0000_AA, 1, '{-1, -1, -1, -1}, 4'h0, 8'h00},
        '{24'h0000_AA, 1, '{4, 4, 4, 4}, 4'hF, 8'h00},
        '{24'h0000_AA, 1, '{4, 4, 4, 4}, 4'h0, 8'h00},
        '{24'h8421_01, 0, '{0, 0, 0, 0}, 4'h0, 8'h00},
        '{24'h8420_01, 0, '{0, 0, 0, 0}, 4'h0, 8'h00},
        '{24'h8421_01, 0, '{0, 0, 0, 0}, 4'h0, 8'h00},
        '{24'h8420_01, 0, '{0, 0, 0, 0}, 4'h0, 8'h00},
        '{24'h8420_01, 0, '{0, 0, 0, 0}, 4'h0, 8'h00},
        '{24'h8420_01, 0, '{0, 0, 0, 0}, 4'h0, 8'h00},
        '{24'h8420_80, 0, '{0, 0, 0, 0}, 4'h0, 8'h00},
        '{24'h96C3_7F, 0, '{0, 0, 0, 0}, 4'h0, 8'h00},
        '{24'hFFFF_FE, 0, '{0, 0, 0, 0}, 4'h0, 8'h00},
        '{24'h0000_00, 0, '{0, 0, 0, 0}, 4'h0, 8'h00},
        '{24'h2222_10, 0, '{0, 0, 0, 0}, 4'h0, 8'h00},
        '{24'h4444_20, 0, '{0, 0, 0, 0}, 4'h0, 8'h00},
        '{24'h1111_40, 0, '{0, 0, 0, 0}, 4'h0, 8'h00},
        '{24'h0000_FF, 0, '{0, 0, 0, 0}, 4'h0, 8'h00}
    };

    rotary_and_button_scan_qualifier i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    function automatic position_t rotary_position(input logic [CODE_W-1:0] code);
        position_t pos;
        pos = POS_INVALID;
        if (code == '0) begin
            pos = POS_NULL;
        end else if ($onehot(code)) begin
            for (int i = 0; i < CODE_W; i++)
                if (code[i]) pos = position_t'(3 - i);
        end
        return pos;
    endfunction

    // Advances the qualifier state by one scan and returns its report.
    function automatic report_t qualify_scan(input scan_t s);
        report_t   rep;
        position_t d;
        bit        moved;
        rep = '0;
        for (int r = 0; r < NUM_ROTARY; r++) begin
            d = rotary_position(s.codes[r]);
            moved = (d != last_decoded[r]);
            if (d == POS_NULL) begin
                if (moved) begin
                    hold_cnt[r] = 16'd1;
                end else if (hold_cnt[r] > hold_thr) begin
                    shown_pos[r] = d;
                    rep.rot_chg[r] = 1'b1;
                    hold_cnt[r] = '0;
                end else if (hold_cnt[r] != '0) begin
                    hold_cnt[r] = hold_cnt[r] + 16'd1;
                end else begin
                    shown_pos[r] = d;
                end
            end else begin
                shown_pos[r] = d;
                rep.rot_chg[r] = moved;
            end
            last_decoded[r] = d;
            rep.pos[r] = shown_pos[r];
        end
        rep.any_chg = |rep.rot_chg;
        rep.btn = s.buttons;
        rep.btn_chg = s.buttons ^ last_buttons;
        last_buttons = s.buttons;
        return rep;
    endfunction

    // Mostly zero (always zero while quiet), sometimes short, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (quiet || r < 65) return 0;
        if (r < 92) return $urandom_range(3, 1);
        return $urandom_range(40, 8);
    endfunction

    // Rotary codes mostly stay put so that nulls live long enough to be qualified.
    function automatic logic [CODE_W-1:0] next_code(input logic [CODE_W-1:0] cur);
        int r;
        r = $urandom_range(99);
        if (r < 65) return cur;
        if (r < 80) return '0;
        if (r < 95) return CODE_W'(1) << $urandom_range(CODE_W - 1);
        return CODE_W'($urandom_range(15));
    endfunction

    task automatic offer_scan(input scan_t s, input bit typed, input report_t typed_rep);
        int      gap;
        report_t rep;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= s;
        do @(posedge aclk); while (!s_tready);
        rep = qualify_scan(s);
        pending_reports.push_back(typed ? typed_rep : rep);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_reports.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_threshold(input logic [THR_W-1:0] thr);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_wdata <= thr;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        hold_thr   = thr;
    endtask

    task automatic check_report(input report_t got);
        report_t want;
        string   lanes;
        lanes = "abcd";
        reports_seen++;
        if (pending_reports.size() == 0) begin
            $error("report item with nothing outstanding: %h", got);
            fail_count++;
        end else begin
            want = pending_reports.pop_front();
            for (int r = 0; r < NUM_ROTARY; r++) begin
                if (got.pos[r] !== want.pos[r]) begin
                    $error("position_%c: expected %0d, got %0d", lanes[r],
                           want.pos[r], got.pos[r]);
                    fail_count++;
                end
            end
            if (got.rot_chg !== want.rot_chg) begin
                $error("rotary_change_bits: expected %b, got %b", want.rot_chg, got.rot_chg);
                fail_count++;
            end
            if (got.any_chg !== want.any_chg) begin
                $error("any_rotary_changed: expected %b, got %b", want.any_chg, got.any_chg);
                fail_count++;
            end
            if (got.btn !== want.btn) begin
                $error("button_levels: expected %h, got %h", want.btn, got.btn);
                fail_count++;
            end
            if (got.btn_chg !== want.btn_chg) begin
                $error("button_change_bits: expected %h, got %h", want.btn_chg, got.btn_chg);
                fail_count++;
            end
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) check_report(m_tdata);
            if (rx_block) begin
                m_tready <= 1'b0;
            end else if (rx_gap > 0) begin
                m_tready <= 1'b0;
                rx_gap = rx_gap - 1;
            end else begin
                m_tready <= 1'b1;
                if ($urandom_range(3) == 0) rx_gap = pick_gap();
            end
        end
    end

    // Long hold-off on the result side; the one-deep output fills and s_tready drops.
    initial begin
        wait (reports_seen >= 250);
        @(posedge aclk);
        rx_block <= 1'b1;
        repeat (HOLD_OFF_LEN) @(posedge aclk);
        rx_block <= 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        logic [THR_W-1:0]  phase_thr [6];
        logic [CODE_W-1:0] lane_code [NUM_ROTARY];
        scan_t             s;
        report_t           rep;

        phase_thr = '{THR_RESET, 16'd0, 16'd2, 16'd65534, THR_W'($urandom_range(6, 1)), 16'd5};
        lane_code = '{default: '0};

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // Threshold 1 lets the directed part walk through every null-hold case.
        write_threshold(16'd1);
        foreach (scan_table[i]) begin
            rep = '0;
            for (int r = 0; r < NUM_ROTARY; r++) rep.pos[r] = scan_table[i].pos[r];
            rep.rot_chg = scan_table[i].rot_chg;
            rep.any_chg = |scan_table[i].rot_chg;
            rep.btn     = scan_table[i].scan[BTN_W-1:0];
            rep.btn_chg = scan_table[i].btn_chg;
            offer_scan(scan_t'(scan_table[i].scan), scan_table[i].typed, rep);
        end

        for (int p = 0; p < 6; p++) begin
            write_threshold(phase_thr[p]);
            quiet = (p == 2);
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                if ($urandom_range(9) == 0) begin
                    s = scan_t'(S_DATA_W'($urandom));          // noise item
                end else begin
                    for (int r = 0; r < NUM_ROTARY; r++) begin
                        lane_code[r] = next_code(lane_code[r]);
                        s.codes[r] = lane_code[r];
                    end
                    s.buttons = BTN_W'($urandom_range(255));
                end
                offer_scan(s, 1'b0, '0);
            end
        end

        wait_drained();
        repeat (4) @(posedge aclk);
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

FILE: sim.f
hdl/rbsq_pkg.sv
hdl/rbsq_lane.sv
hdl/rbsq_merge.sv
hdl/rotary_and_button_scan_qualifier.sv
sim/tb_top.sv
